// File: rtl/core/rwq_pkg.sv
// ----------------------------------------------------------------------------
// rwq_pkg: shared types and constants for the region window query block
// Holds table sizing, command and status codes, and the item structs.
// ----------------------------------------------------------------------------
package rwq_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 14;
  localparam int IDX_BITS   = $clog2(MAX_BOXES);
  localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);
  localparam int WIN_BITS   = COORD_BITS + 3;
  localparam int RESULT_CAP = 64;
  localparam int NCAP_BITS  = $clog2(RESULT_CAP + 1);
  localparam int QDEPTH     = 2;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_LOAD   = 3'd1;
  localparam logic [2:0] CMD_RIGHT  = 3'd2;
  localparam logic [2:0] CMD_BELOW  = 3'd3;
  localparam logic [2:0] CMD_ABOVE  = 3'd4;
  localparam logic [2:0] CMD_INSIDE = 3'd5;

  localparam logic [2:0] ST_CLEARED = 3'd0;
  localparam logic [2:0] ST_LOADED  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_MATCH   = 3'd3;
  localparam logic [2:0] ST_NOMATCH = 3'd4;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]            command;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_right;
    logic [COORD_BITS-1:0] box_bottom;
    logic [5:0]            box_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [5:0]            match_id;
    logic [COORD_BITS-1:0] match_left;
    logic [COORD_BITS-1:0] match_top;
    logic [COORD_BITS-1:0] match_right;
    logic [COORD_BITS-1:0] match_bottom;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic [5:0]            id;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] s;
    logic [COORD_BITS-1:0] t;
  } box_t;

  // classified job: command, box and signed window
  typedef struct packed {
    logic [2:0]          command;
    box_t                box;
    logic signed [WIN_BITS-1:0] wl;
    logic signed [WIN_BITS-1:0] wr;
    logic signed [WIN_BITS-1:0] wt;
    logic signed [WIN_BITS-1:0] wb;
  } job_t;

endpackage

// File: rtl/core/rwq_front.sv
// ----------------------------------------------------------------------------
// rwq_front: command intake and window classifier
// Registers one accepted item, forms its search window and pushes a job; an item with an unknown command is dropped.
// ----------------------------------------------------------------------------
module rwq_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  rwq_pkg::in_item_t item,
  input  logic [11:0]      rx,
  input  logic [11:0]      ry,
  input  logic             q_full,
  output logic             push,
  output rwq_pkg::job_t    job,
  output logic             hold
);

  localparam int W = rwq_pkg::WIN_BITS;

  logic              vld_r;
  rwq_pkg::in_item_t it_r;
  logic signed [W-1:0] x, y, s, t, rxs, rys, rx3, ry3, rxc, ry2, ry4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (push || (vld_r && it_r.command > rwq_pkg::CMD_INSIDE)) begin
      vld_r <= 1'b0;
    end
    if (take) begin
      it_r <= item;
    end
  end

  assign hold = vld_r;

  always_comb begin
    x   = W'(it_r.box_left);
    y   = W'(it_r.box_top);
    s   = W'(it_r.box_right);
    t   = W'(it_r.box_bottom);
    rxs = W'(rx);
    rys = W'(ry);
    rx3 = rxs + (rxs <<< 1);
    ry3 = rys + (rys <<< 1);
    rxc = (rx3 + W'(3)) >>> 2;
    ry2 = rys >>> 1;
    ry4 = rys >>> 2;
    job.command = it_r.command;
    job.box = '{id: it_r.box_id, x: it_r.box_left, y: it_r.box_top,
                s: it_r.box_right, t: it_r.box_bottom};
    case (it_r.command)
      rwq_pkg::CMD_RIGHT: begin
        job.wl = s - rxc; job.wr = s + rx3; job.wt = y - ry2; job.wb = t + ry2;
      end
      rwq_pkg::CMD_BELOW: begin
        job.wl = x - rxs; job.wr = s + rxs; job.wt = t - ry4; job.wb = t + ry3;
      end
      rwq_pkg::CMD_ABOVE: begin
        job.wl = x - rxs; job.wr = s + rxs; job.wt = y - ry3; job.wb = y + ry4;
      end
      default: begin
        job.wl = x + W'(1); job.wr = s + rxs; job.wt = y + W'(1); job.wb = t + rys;
      end
    endcase
  end

  assign push = vld_r && !q_full && it_r.command <= rwq_pkg::CMD_INSIDE;

endmodule

// File: rtl/core/rwq_queue.sv
// ----------------------------------------------------------------------------
// rwq_queue: short job queue
// Decouples the classifier from the table engine.
// ----------------------------------------------------------------------------
module rwq_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rwq_pkg::job_t din,
  input  logic          pop,
  output rwq_pkg::job_t dout,
  output logic          empty,
  output logic          full
);

  localparam int AW = $clog2(rwq_pkg::QDEPTH);

  rwq_pkg::job_t mem_r [rwq_pkg::QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= din;
  end

  assign dout  = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (AW+1)'(rwq_pkg::QDEPTH));

endmodule

// File: rtl/core/rwq_back.sv
// ----------------------------------------------------------------------------
// rwq_back: table engine
// Inserts boxes by shifting, binary-searches the window start and scans.
// ----------------------------------------------------------------------------
module rwq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  rwq_pkg::job_t     job,
  output logic              pop,
  output logic              idle,
  output logic              res_vld,
  output rwq_pkg::out_item_t res
);

  localparam int IB = rwq_pkg::IDX_BITS;
  localparam int CB = rwq_pkg::CNT_BITS;
  localparam int NB = rwq_pkg::NCAP_BITS;
  localparam int W  = rwq_pkg::WIN_BITS;

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SRCH, S_SRCH_W, S_SCAN, S_SCAN_W}
    state_t;

  state_t        st_r;
  rwq_pkg::job_t jb_r;
  rwq_pkg::box_t mem_r [rwq_pkg::MAX_BOXES];
  rwq_pkg::box_t rd_r;
  logic [CB-1:0] cnt_r, lo_r, hi_r, pos_r;
  logic [CB-1:0] mid;
  logic [NB-1:0] n_r;
  logic          pend_r;
  rwq_pkg::box_t pbox_r;
  logic          res_vld_r;
  rwq_pkg::out_item_t res_r;
  logic          wr_en;
  logic [IB-1:0] wr_a, rd_a;
  rwq_pkg::box_t wr_d;
  logic          hit;
  logic signed [W-1:0] dx, dy, dt;

  assign mid = CB'((lo_r + hi_r) >> 1);
  assign dx  = W'(rd_r.x);
  assign dy  = W'(rd_r.y);
  assign dt  = W'(rd_r.t);

  always_comb begin
    case (jb_r.command)
      rwq_pkg::CMD_BELOW: hit = dy <= jb_r.wb && dy >= jb_r.wt;
      rwq_pkg::CMD_ABOVE: hit = dt <= jb_r.wb && dt >= jb_r.wt;
      default:            hit = dy <= jb_r.wb && dt >= jb_r.wt;
    endcase
  end

  // memory port control
  always_comb begin
    wr_en = 1'b0;
    wr_a  = pos_r[IB-1:0];
    wr_d  = rd_r;
    rd_a  = '0;
    case (st_r)
      S_SHIFT: begin
        rd_a = IB'(pos_r - 1'b1);
        if (pos_r != '0 && rd_r.x > jb_r.box.x) begin
          wr_en = 1'b1; wr_d = rd_r;
        end else begin
          wr_en = 1'b1; wr_d = jb_r.box;
        end
      end
      S_SRCH:  rd_a = mid[IB-1:0];
      S_SCAN:  rd_a = pos_r[IB-1:0];
      default: rd_a = IB'(pos_r - 1'b1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_a] <= wr_d;
    rd_r <= mem_r[rd_a];
  end

  assign pop = (st_r == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      res_vld_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            jb_r <= job;
            case (job.command)
              rwq_pkg::CMD_CLEAR: begin
                cnt_r <= '0;
                res_vld_r <= 1'b1;
                res_r <= '{status: rwq_pkg::ST_CLEARED, last: 1'b1, default: '0};
              end
              rwq_pkg::CMD_LOAD: begin
                if (cnt_r == CB'(rwq_pkg::MAX_BOXES)) begin
                  res_vld_r <= 1'b1;
                  res_r <= '{status: rwq_pkg::ST_FULL, last: 1'b1, default: '0};
                end else begin
                  res_vld_r <= 1'b0;
                  pos_r <= cnt_r;
                  st_r  <= S_SRCH_W;  // prime read of pos-1, then shift
                end
              end
              default: begin
                res_vld_r <= 1'b0;
                lo_r   <= '0;
                hi_r   <= cnt_r;
                n_r    <= '0;
                pend_r <= 1'b0;
                st_r   <= S_SRCH;
              end
            endcase
          end else begin
            res_vld_r <= 1'b0;
          end
        end
        S_SRCH_W: begin
          res_vld_r <= 1'b0;
          if (jb_r.command == rwq_pkg::CMD_LOAD) st_r <= S_SHIFT;
          else begin
            // compare fetched midpoint
            if (jb_r.wl <= dx) hi_r <= mid;
            else lo_r <= mid + 1'b1;
            st_r <= S_SRCH;
          end
        end
        S_SHIFT: begin
          if (pos_r != '0 && rd_r.x > jb_r.box.x) begin
            res_vld_r <= 1'b0;
            pos_r <= pos_r - 1'b1;
            st_r  <= S_SRCH_W;
          end else begin
            cnt_r     <= cnt_r + 1'b1;
            res_vld_r <= 1'b1;
            res_r <= '{status: rwq_pkg::ST_LOADED, last: 1'b1, default: '0};
            st_r  <= S_IDLE;
          end
        end
        S_SRCH: begin
          res_vld_r <= 1'b0;
          if (lo_r < hi_r) st_r <= S_SRCH_W;
          else begin
            pos_r <= lo_r;
            st_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pos_r < cnt_r) st_r <= S_SCAN_W;
          else st_r <= S_IDLE;
          res_vld_r <= (pos_r >= cnt_r);
          if (pos_r >= cnt_r) begin
            if (pend_r)
              res_r <= '{status: rwq_pkg::ST_MATCH, match_id: pbox_r.id,
                         match_left: pbox_r.x, match_top: pbox_r.y,
                         match_right: pbox_r.s, match_bottom: pbox_r.t, last: 1'b1};
            else
              res_r <= '{status: rwq_pkg::ST_NOMATCH, last: 1'b1, default: '0};
          end
        end
        S_SCAN_W: begin
          if (dx > jb_r.wr) begin
            res_vld_r <= 1'b1;
            if (pend_r)
              res_r <= '{status: rwq_pkg::ST_MATCH, match_id: pbox_r.id,
                         match_left: pbox_r.x, match_top: pbox_r.y,
                         match_right: pbox_r.s, match_bottom: pbox_r.t, last: 1'b1};
            else
              res_r <= '{status: rwq_pkg::ST_NOMATCH, last: 1'b1, default: '0};
            st_r <= S_IDLE;
          end else if (hit) begin
            res_vld_r <= pend_r;
            if (pend_r) begin
              res_r <= '{status: rwq_pkg::ST_MATCH, match_id: pbox_r.id,
                         match_left: pbox_r.x, match_top: pbox_r.y,
                         match_right: pbox_r.s, match_bottom: pbox_r.t, last: 1'b0};
            end
            pend_r <= 1'b1;
            pbox_r <= rd_r;
            n_r    <= n_r + NB'(pend_r);
            // cap reached: this hit becomes the final result
            if (n_r + NB'(pend_r) == NB'(rwq_pkg::RESULT_CAP - 1)) begin
              pos_r <= cnt_r;
            end else begin
              pos_r <= pos_r + 1'b1;
            end
            st_r <= S_SCAN;
          end else begin
            res_vld_r <= 1'b0;
            pos_r <= pos_r + 1'b1;
            st_r  <= S_SCAN;
          end
        end
        default: begin
          res_vld_r <= 1'b0;
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign idle    = (st_r == S_IDLE);
  assign res_vld = res_vld_r;
  assign res     = res_r;

  a_last_on_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.status != rwq_pkg::ST_MATCH |-> res.last)
    else $error("non-match result without last");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CB'(rwq_pkg::MAX_BOXES))
    else $error("box count above capacity");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> st_r != S_IDLE || res_vld)
    else $error("job popped without effect");

endmodule

// File: rtl/core/region_window_query.sv
// ----------------------------------------------------------------------------
// region_window_query: x-sorted box table with relation window queries
// Front classifier, job queue and table engine.
// ----------------------------------------------------------------------------
// Only one item is in flight: busy rises at the accepting edge and falls once
// the engine is idle again. An unknown command gives no result; a clear or a
// load into a full table gives one; a load shifts up each stored box with a
// larger left edge; a query runs binary-search steps (at most
// ceil(log2(count+1)) steps over the table), then scans the candidates, with
// results leaving as the scan goes. Results appear on out_valid for one cycle
// and cannot be held off.
module region_window_query (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rwq_pkg::in_item_t   in_item,
  output logic                out_valid,
  output rwq_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [11:0]         cfg_data
);

  logic [11:0] rx_r, ry_r;
  logic        take, push, hold, q_empty, q_full, pop, b_idle;
  logic        busy_r;
  rwq_pkg::job_t job_in, job_out;

  assign cfg_ready = 1'b1;

  // hold the window sizes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r <= 12'd32;
      ry_r <= 12'd32;
    end else if (cfg_valid) begin
      if (cfg_index == rwq_pkg::REG_WIDTH)  rx_r <= cfg_data;
      if (cfg_index == rwq_pkg::REG_HEIGHT) ry_r <= cfg_data;
    end
  end

  assign take = start && !busy;
  // busy from accept until the engine drains
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else if (take) busy_r <= 1'b1;
    else if (!hold && q_empty && b_idle && !pop) busy_r <= 1'b0;
  end
  assign busy = busy_r;

  rwq_front u_front (.clk, .rst_n, .take, .item(in_item), .rx(rx_r), .ry(ry_r),
                     .q_full, .push, .job(job_in), .hold);
  rwq_queue u_queue (.clk, .rst_n, .push, .din(job_in), .pop, .dout(job_out),
                     .empty(q_empty), .full(q_full));
  rwq_back  u_back  (.clk, .rst_n, .q_empty, .job(job_out), .pop, .idle(b_idle),
                     .res_vld(out_valid), .res(out_item));

endmodule

// File: tb/region_window_query_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// region_window_query_test: self-checking bench for the box table query block
// Drives clear, load and relation queries at random pacing, predicts every
// result from a private copy of the sorted box table, and checks each one.
// ----------------------------------------------------------------------------
module region_window_query_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int COORD_W        = rwq_pkg::COORD_BITS;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  rwq_pkg::in_item_t   in_item;
  logic                out_valid;
  rwq_pkg::out_item_t  out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [11:0]         cfg_data;

  int error_count;
  int idle_cycles;

  region_window_query DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // Scoreboard: mirror of the table and registers, plus the queue of
  // results still owed by the block.
  class query_scoreboard;
    rwq_pkg::box_t      boxes[$];
    logic [11:0]        width_reg;
    logic [11:0]        height_reg;
    rwq_pkg::out_item_t pending_results[$];

    function new();
      width_reg  = 12'd32;
      height_reg = 12'd32;
    endfunction

    function void set_reg(input logic idx, input logic [11:0] value);
      if (idx == rwq_pkg::REG_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    function void owe(input rwq_pkg::out_item_t r);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function rwq_pkg::out_item_t blank(input logic [2:0] st);
      rwq_pkg::out_item_t r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
    endfunction

    function rwq_pkg::out_item_t hit_item(input rwq_pkg::box_t b, input logic is_last);
      rwq_pkg::out_item_t r;
      r.status       = rwq_pkg::ST_MATCH;
      r.match_id     = b.id;
      r.match_left   = b.x;
      r.match_top    = b.y;
      r.match_right  = b.s;
      r.match_bottom = b.t;
      r.last         = is_last;
      return r;
    endfunction

    // Note an accepted input item and queue what it must produce.
    function void note_item(input rwq_pkg::in_item_t it);
      longint        rx, ry, wl, wr, wt, wb, x, y, s, t, by, bt, bx;
      int            pos, n, hit_idx[$];
      rwq_pkg::box_t b;
      logic          ok;
      rx = width_reg; ry = height_reg;
      x = it.box_left; y = it.box_top; s = it.box_right; t = it.box_bottom;
      case (it.command)
        rwq_pkg::CMD_CLEAR: begin
          boxes.delete();
          owe(blank(rwq_pkg::ST_CLEARED));
          return;
        end
        rwq_pkg::CMD_LOAD: begin
          if (boxes.size() >= rwq_pkg::MAX_BOXES) begin
            owe(blank(rwq_pkg::ST_FULL));
            return;
          end
          b.id = it.box_id; b.x = it.box_left; b.y = it.box_top;
          b.s = it.box_right; b.t = it.box_bottom;
          // equal left edges go after the ones already stored
          pos = boxes.size();
          while (pos > 0 && boxes[pos-1].x > b.x) pos--;
          boxes.insert(pos, b);
          owe(blank(rwq_pkg::ST_LOADED));
          return;
        end
        rwq_pkg::CMD_RIGHT: begin
          wl = s - (3*rx + 3)/4; wr = s + 3*rx; wt = y - ry/2; wb = t + ry/2;
        end
        rwq_pkg::CMD_BELOW: begin
          wl = x - rx; wr = s + rx; wt = t - ry/4; wb = t + 3*ry;
        end
        rwq_pkg::CMD_ABOVE: begin
          wl = x - rx; wr = s + rx; wt = y - 3*ry; wb = y + ry/4;
        end
        rwq_pkg::CMD_INSIDE: begin
          wl = x + 1; wr = s + rx; wt = y + 1; wb = t + ry;
        end
        default: return;
      endcase
      foreach (boxes[i]) begin
        bx = longint'(boxes[i].x);
        if (bx < wl) continue;
        if (bx > wr || hit_idx.size() == rwq_pkg::RESULT_CAP) break;
        by = boxes[i].y; bt = boxes[i].t;
        if (it.command == rwq_pkg::CMD_BELOW) ok = (by <= wb) && (by >= wt);
        else if (it.command == rwq_pkg::CMD_ABOVE) ok = (bt <= wb) && (bt >= wt);
        else ok = (by <= wb) && (bt >= wt);
        if (ok) hit_idx.insert(hit_idx.size(), i);
      end
      n = hit_idx.size();
      if (n == 0) owe(blank(rwq_pkg::ST_NOMATCH));
      foreach (hit_idx[k])
        owe(hit_item(boxes[hit_idx[k]], k == n - 1));
    endfunction

    // Compare one result from the block against the oldest expectation.
    task check_result(input rwq_pkg::out_item_t got);
      rwq_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
      if (got.match_id !== want.match_id)
        report_mismatch($sformatf("id %0d want %0d", got.match_id, want.match_id));
      if (got.match_left !== want.match_left)
        report_mismatch($sformatf("left %0d want %0d", got.match_left, want.match_left));
      if (got.match_top !== want.match_top)
        report_mismatch($sformatf("top %0d want %0d", got.match_top, want.match_top));
      if (got.match_right !== want.match_right)
        report_mismatch($sformatf("right %0d want %0d", got.match_right,
                                  want.match_right));
      if (got.match_bottom !== want.match_bottom)
        report_mismatch($sformatf("bottom %0d want %0d", got.match_bottom,
                                  want.match_bottom));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
    endtask
  endclass

  query_scoreboard board;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample at the rising edge: accept results, note accepted items, and
  // count cycles in which nothing moved.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_result(out_item);
      if (start && !busy) board.note_item(in_item);
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d quiet cycles", idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one, often none at all.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 4) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    repeat (n) @(negedge clk);
  endtask

  // Present one item at the falling edge and hold it until accepted.
  task automatic send_item(input rwq_pkg::in_item_t it);
    idle_gap();
    in_item = it;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start   = 1'b0;
    in_item = '0;
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drain every owed result, then give the block room for any item that
  // leaves no result (ignored commands).
  task automatic wait_drained();
    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic rwq_pkg::in_item_t make_item(input logic [2:0] c, input int x,
                                                  input int y, input int s,
                                                  input int t, input int id);
    rwq_pkg::in_item_t it;
    it.command = c; it.box_left = COORD_W'(x); it.box_top = COORD_W'(y);
    it.box_right = COORD_W'(s); it.box_bottom = COORD_W'(t); it.box_id = 6'(id);
    return it;
  endfunction

  // Random box clustered in a small area so queries find neighbors; some
  // boxes land anywhere in the coordinate range.
  function automatic rwq_pkg::in_item_t rand_item(input logic [2:0] c, input int base);
    int x, y;
    if ($urandom_range(0, 9) == 0)
      return make_item(c, $urandom_range(0, 16383), $urandom_range(0, 16383),
                       $urandom_range(0, 16383), $urandom_range(0, 16383),
                       $urandom_range(0, 63));
    x = base + $urandom_range(0, 400);
    y = base + $urandom_range(0, 400);
    return make_item(c, x, y, x + $urandom_range(0, 60), y + $urandom_range(0, 60),
                     $urandom_range(0, 63));
  endfunction

  task automatic random_phase(input int count);
    int base, pick;
    logic [2:0] c;
    base = $urandom_range(0, 15900);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) c = rwq_pkg::CMD_CLEAR;
      else if (pick < 45) c = rwq_pkg::CMD_LOAD;
      else if (pick < 97) c = 3'(rwq_pkg::CMD_RIGHT + $urandom_range(0, 3));
      else c = 3'(3'd6 + $urandom_range(0, 1));
      send_item(rand_item(c, base));
    end
  endtask

  initial begin
    board       = new();
    error_count = 0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = rwq_pkg::REG_WIDTH;
    cfg_data    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, every relation, ties, odd boxes, unknown commands.
    send_item(make_item(rwq_pkg::CMD_RIGHT, 0, 0, 0, 0, 0));
    send_item(make_item(rwq_pkg::CMD_LOAD, 100, 100, 120, 120, 1));
    send_item(make_item(rwq_pkg::CMD_LOAD, 100, 110, 130, 140, 2));
    send_item(make_item(rwq_pkg::CMD_LOAD, 50, 90, 40, 80, 63));
    send_item(make_item(rwq_pkg::CMD_LOAD, 130, 100, 150, 125, 3));
    send_item(make_item(rwq_pkg::CMD_LOAD, 16383, 16383, 16383, 16383, 4));
    send_item(make_item(rwq_pkg::CMD_LOAD, 0, 0, 0, 0, 5));
    send_item(make_item(rwq_pkg::CMD_LOAD, 105, 150, 125, 170, 6));
    send_item(make_item(rwq_pkg::CMD_RIGHT, 90, 100, 110, 120, 0));
    send_item(make_item(rwq_pkg::CMD_BELOW, 95, 100, 120, 130, 0));
    send_item(make_item(rwq_pkg::CMD_ABOVE, 95, 160, 120, 170, 0));
    send_item(make_item(rwq_pkg::CMD_INSIDE, 99, 99, 130, 130, 0));
    send_item(make_item(rwq_pkg::CMD_INSIDE, 16383, 16383, 16383, 16383, 63));
    send_item(make_item(3'd6, 100, 100, 100, 100, 7));
    send_item(make_item(3'd7, 16383, 0, 16383, 0, 63));
    send_item(make_item(rwq_pkg::CMD_ABOVE, 0, 0, 0, 0, 0));
    send_item(make_item(rwq_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_item(rwq_pkg::CMD_BELOW, 100, 100, 120, 120, 0));
    wait_drained();

    // Fill the table with one crowded cluster, overflow it, and hit the cap.
    write_reg(rwq_pkg::REG_WIDTH, 12'd4095);
    write_reg(rwq_pkg::REG_HEIGHT, 12'd4095);
    for (int i = 0; i < rwq_pkg::MAX_BOXES + 2; i++)
      send_item(make_item(rwq_pkg::CMD_LOAD, 8000 + (i % 8), 8000, 8010, 8010, i));
    send_item(make_item(rwq_pkg::CMD_INSIDE, 7000, 7000, 9000, 9000, 0));
    send_item(make_item(rwq_pkg::CMD_RIGHT, 7000, 7000, 7990, 9000, 0));
    wait_drained();
    send_item(make_item(rwq_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));

    // Random phases, each under its own register setting.
    random_phase(4);
    wait_drained();
    write_reg(rwq_pkg::REG_WIDTH, 12'd1);
    write_reg(rwq_pkg::REG_HEIGHT, 12'd0);
    random_phase(3);
    wait_drained();
    write_reg(rwq_pkg::REG_WIDTH, 12'd0);
    write_reg(rwq_pkg::REG_HEIGHT, 12'd1);
    send_item(make_item(rwq_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
    random_phase(3);
    wait_drained();
    write_reg(rwq_pkg::REG_WIDTH, 12'($urandom_range(20, 120)));
    write_reg(rwq_pkg::REG_HEIGHT, 12'($urandom_range(20, 120)));
    random_phase(4);

    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && board.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/rwq_pkg.sv
rtl/core/rwq_front.sv
rtl/core/rwq_queue.sv
rtl/core/rwq_back.sv
rtl/core/region_window_query.sv
tb/region_window_query_test.sv
